>>> rtl/rpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_pkg: shared types and constants of the page allocator
// Request and status codes, controller states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package rpa_pkg;

  localparam int unsigned MAX_PAGES_DEF  = 4096;
  localparam int unsigned COUNT_BITS_DEF = 8;
  localparam int unsigned PAGE_W_DEF     = $clog2(MAX_PAGES_DEF);
  localparam int unsigned TOP_W_DEF      = $clog2(MAX_PAGES_DEF + 1);
  localparam int unsigned STATUS_W       = 3;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_ADD   = 2'd2,
    ACT_QUERY = 2'd3
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BUSY      = 3'd2,
    ST_FREE_ZERO = 3'd3,
    ST_REF_ZERO  = 3'd4,
    ST_SATURATED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_CNT,
    S_EXEC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic in_rdy;     // request channel may take a word
    logic rd_popped;  // read the count of the popped page
    logic exec;       // update memories and load the result word
    logic clr_wr;     // clear one count entry
  } rpa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_valid;
    logic in_alloc;
    logic cfg_fire;
    logic clr_last;
    logic out_free;
  } rpa_sts_t;

endpackage

>>> rtl/rpa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_if: channel interfaces of the page allocator
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface rpa_req_if #(
  parameter int unsigned PAGE_W = rpa_pkg::PAGE_W_DEF
);
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [PAGE_W-1:0] page_index;

  modport source (output valid, action, page_index, input ready);
  modport sink   (input valid, action, page_index, output ready);
endinterface

interface rpa_rsp_if #(
  parameter int unsigned PAGE_W     = rpa_pkg::PAGE_W_DEF,
  parameter int unsigned COUNT_BITS = rpa_pkg::COUNT_BITS_DEF,
  parameter int unsigned TOP_W      = rpa_pkg::TOP_W_DEF
);
  logic                          valid;
  logic                          ready;
  logic [PAGE_W-1:0]             granted_page;
  logic [COUNT_BITS-1:0]         ref_count;
  logic [TOP_W-1:0]              free_pages;
  logic [rpa_pkg::STATUS_W-1:0]  status;

  modport source (output valid, granted_page, ref_count, free_pages, status, input ready);
  modport sink   (input valid, granted_page, ref_count, free_pages, status, output ready);
endinterface

interface rpa_cfg_if #(
  parameter int unsigned TOP_W = rpa_pkg::TOP_W_DEF
);
  logic             valid;
  logic             ready;
  logic [TOP_W-1:0] pages_in_use;

  modport source (output valid, pages_in_use, input ready);
  modport sink   (input valid, pages_in_use, output ready);
endinterface

>>> rtl/rpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered and held when idle.
// ----------------------------------------------------------------------------
module rpa_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_ctrl: request sequencer of the page allocator
// Runs the count clear pass, takes one request at a time and steps it
// through the memory reads to the update cycle.
// ----------------------------------------------------------------------------
module rpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  rpa_pkg::rpa_sts_t sts,
  output rpa_pkg::rpa_cmd_t cmd
);
  import rpa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_rdy = !sts.cfg_fire;
        if (sts.in_valid && cmd.in_rdy) begin
          state_nxt = sts.in_alloc ? S_RD_CNT : S_EXEC;
        end
      end
      S_RD_CNT: begin
        cmd.rd_popped = 1'b1;
        state_nxt     = S_EXEC;
      end
      S_EXEC: begin
        // hold the read data until the result register has room
        if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
    // a new page count restarts the clear pass
    if (sts.cfg_fire) begin
      state_nxt = S_CLEAR;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.in_rdy && sts.in_valid) |=> !cmd.in_rdy)
    else $error("request taken while another is in flight");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && sts.clr_last && !sts.cfg_fire) |=> state_r == S_IDLE)
    else $error("clear pass did not end after last entry");

endmodule

>>> rtl/rpa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpa_dp: datapath of the page allocator
// Free stack and reference count memories, stack pointer, low-water mark,
// clear counter and the result register.
// ----------------------------------------------------------------------------
module rpa_dp #(
  parameter int unsigned MAX_PAGES  = rpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  rpa_req_if.sink           in_ch,
  rpa_rsp_if.source         out_ch,
  rpa_cfg_if.sink           cfg_ch,
  input  rpa_pkg::rpa_cmd_t cmd,
  output rpa_pkg::rpa_sts_t sts
);
  import rpa_pkg::*;

  localparam int unsigned PAGE_W = $clog2(MAX_PAGES);
  localparam int unsigned TOP_W  = $clog2(MAX_PAGES + 1);
  localparam logic [TOP_W-1:0]      MAX_TOP  = TOP_W'(MAX_PAGES);
  localparam logic [PAGE_W-1:0]     LAST_IDX = PAGE_W'(MAX_PAGES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

  logic [TOP_W-1:0]      pages_r;
  logic [TOP_W-1:0]      top_r;
  logic [TOP_W-1:0]      top_nxt;
  logic [TOP_W-1:0]      low_r;   // lowest stack pointer since refill
  logic [PAGE_W-1:0]     clr_idx_r;
  act_t                  act_r;
  logic [PAGE_W-1:0]     page_r;
  logic [PAGE_W-1:0]     pop_r;

  logic                  out_valid_r;
  logic [PAGE_W-1:0]     granted_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [TOP_W-1:0]      free_r;
  status_t               status_r;

  logic                  accept;
  logic                  cfg_fire;
  logic [TOP_W-1:0]      cfg_v;
  logic [TOP_W-1:0]      top_m1;
  logic [PAGE_W-1:0]     pop_src;
  logic                  in_range;
  logic [COUNT_BITS-1:0] cur;

  logic [PAGE_W-1:0]     stk_rdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  cnt_we;
  logic [PAGE_W-1:0]     cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [PAGE_W-1:0]     cnt_raddr;

  logic [PAGE_W-1:0]     granted;
  logic [COUNT_BITS-1:0] cnt_out;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  cnt_upd;
  logic                  push;
  status_t               st;

  assign accept   = cmd.in_rdy && in_ch.valid;
  assign cfg_fire = cfg_ch.valid;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = cmd.in_rdy;

  // zero reads as one page, anything above the maximum as the maximum
  always_comb begin
    cfg_v = cfg_ch.pages_in_use;
    if (cfg_v == '0) begin
      cfg_v = TOP_W'(1);
    end else if (cfg_v > MAX_TOP) begin
      cfg_v = MAX_TOP;
    end
  end

  assign top_m1 = top_r - 1'b1;
  // entries below the low-water mark were never rewritten and still hold
  // their own index
  assign pop_src  = (top_m1 >= low_r) ? stk_rdata : top_m1[PAGE_W-1:0];
  assign in_range = TOP_W'(page_r) < MAX_TOP;
  assign cur      = in_range ? cnt_rdata : '0;

  always_comb begin
    granted = '0;
    cnt_out = '0;
    cnt_new = cur;
    cnt_upd = 1'b0;
    push    = 1'b0;
    top_nxt = top_r;
    st      = ST_OK;
    unique case (act_r)
      ACT_ALLOC: begin
        if (top_r == '0) begin
          st = ST_EMPTY;
        end else begin
          top_nxt = top_m1;
          granted = pop_r;
          if (cnt_rdata != '0) begin
            st      = ST_BUSY;
            cnt_out = cnt_rdata;
          end else begin
            cnt_new = CNT_ONE;
            cnt_upd = 1'b1;
            cnt_out = CNT_ONE;
          end
        end
      end
      ACT_FREE: begin
        if (cur == '0) begin
          st = ST_FREE_ZERO;
        end else begin
          cnt_new = cur - 1'b1;
          cnt_upd = 1'b1;
          cnt_out = cur - 1'b1;
          if (cur == CNT_ONE && top_r < MAX_TOP) begin
            push    = 1'b1;
            top_nxt = top_r + 1'b1;
          end
        end
      end
      ACT_ADD: begin
        if (cur == '0) begin
          st = ST_REF_ZERO;
        end else if (cur == CNT_MAX) begin
          st      = ST_SATURATED;
          cnt_out = cur;
        end else begin
          cnt_new = cur + 1'b1;
          cnt_upd = 1'b1;
          cnt_out = cur + 1'b1;
        end
      end
      ACT_QUERY: cnt_out = cur;
    endcase
  end

  assign cnt_raddr = cmd.rd_popped ? pop_src : in_ch.page_index;
  assign cnt_we    = cmd.clr_wr || (cmd.exec && cnt_upd);
  assign cnt_wdata = cmd.clr_wr ? '0 : cnt_new;
  always_comb begin
    if (cmd.clr_wr) begin
      cnt_waddr = clr_idx_r;
    end else if (act_r == ACT_ALLOC) begin
      cnt_waddr = pop_r;
    end else begin
      cnt_waddr = page_r;
    end
  end

  rpa_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_stack (
    .clk   (clk),
    .we    (cmd.exec && push),
    .waddr (top_r[PAGE_W-1:0]),
    .wdata (page_r),
    .re    (accept),
    .raddr (top_m1[PAGE_W-1:0]),
    .rdata (stk_rdata)
  );

  rpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_PAGES)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept || cmd.rd_popped),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pages_r   <= MAX_TOP;
      top_r     <= MAX_TOP;
      low_r     <= MAX_TOP;
      clr_idx_r <= '0;
    end else if (cfg_fire) begin
      pages_r   <= cfg_v;
      top_r     <= cfg_v;
      low_r     <= cfg_v;
      clr_idx_r <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cmd.exec) begin
        top_r <= top_nxt;
        if (top_nxt < low_r) begin
          low_r <= top_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= act_t'(in_ch.action);
      page_r <= in_ch.page_index;
    end
    if (cmd.rd_popped) begin
      pop_r <= pop_src;
    end
    if (cmd.exec) begin
      granted_r <= granted;
      count_r   <= cnt_out;
      free_r    <= top_nxt;
      status_r  <= st;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted_page = granted_r;
  assign out_ch.ref_count    = count_r;
  assign out_ch.free_pages   = free_r;
  assign out_ch.status       = status_r;

  assign sts.in_valid = in_ch.valid;
  assign sts.in_alloc = act_t'(in_ch.action) == ACT_ALLOC;
  assign sts.cfg_fire = cfg_fire;
  assign sts.clr_last = clr_idx_r == LAST_IDX;
  assign sts.out_free = !out_valid_r || out_ch.ready;

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= pages_r)
    else $error("stack pointer above managed page count");

  a_low_bound: assert property (@(posedge clk) disable iff (!rst_n)
    low_r <= top_r)
    else $error("low-water mark above stack pointer");

  a_exec_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || out_ch.ready))
    else $error("result word overwritten before it was taken");

endmodule

>>> rtl/refcounted_page_allocator.sv
`timescale 1ns / 1ps
// Free, add and query results are loaded into the result word after the count read
//   of the request's page; allocate results after the stack read, then the count read
//   of the popped page. A result waits until the result register has room.
// One request is taken at a time, as the count memory is read registered ahead
//   of its write-back. Reset and every configuration write clear all MAX_PAGES
//   counts in a pass; requests wait meanwhile, configuration words are always taken.
// ----------------------------------------------------------------------------
// refcounted_page_allocator: free-list page allocator with reference counts
// Pops pages off a free stack, tracks a saturating count per page and pushes
// a page back when its last reference is freed. Faults come back as status.
// ----------------------------------------------------------------------------
module refcounted_page_allocator #(
  parameter int unsigned MAX_PAGES  = rpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rpa_req_if.sink   in_ch,
  rpa_rsp_if.source out_ch,
  rpa_cfg_if.sink   cfg_ch
);
  import rpa_pkg::*;

  rpa_cmd_t cmd;
  rpa_sts_t sts;

  rpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  rpa_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule
